[design/ghe_pkg.sv]
// ----------------------------------------------------------------------------
// ghe_pkg
// Shared types and constants for the gray-level histogram engine.
// ----------------------------------------------------------------------------
package ghe_pkg;

   localparam int NUM_BINS        = 256;
   localparam int BIN_IDX_BITS    = $clog2(NUM_BINS);
   localparam int PIX_BITS        = 8;
   localparam int OP_BITS         = 2;
   localparam int OUT_COUNT_BITS  = 24;
   localparam int BAR_BITS        = 8;
   localparam int COUNT_BITS_DEF  = 24;

   localparam logic [OUT_COUNT_BITS-1:0] OUT_COUNT_MAX = {OUT_COUNT_BITS{1'b1}};
   localparam logic [BAR_BITS-1:0]       BAR_MAX       = {BAR_BITS{1'b1}};

   typedef enum logic [OP_BITS-1:0] {
      OP_COUNT = 2'd0,
      OP_READ  = 2'd1,
      OP_CLEAR = 2'd2
   } op_type;

endpackage

[design/ghe_req_if.sv]
// ----------------------------------------------------------------------------
// ghe_req_if
// Operation channel of the histogram engine: valid/ready plus one request word.
// ----------------------------------------------------------------------------
interface ghe_req_if;
   import ghe_pkg::*;

   logic                    valid;
   logic                    ready;
   logic [OP_BITS-1:0]      operation;
   logic [PIX_BITS-1:0]     pixel_value;
   logic [BIN_IDX_BITS-1:0] bin_index;

   modport source (output valid, output operation, output pixel_value,
                   output bin_index, input ready);
   modport sink   (input valid, input operation, input pixel_value,
                   input bin_index, output ready);
endinterface

[design/ghe_rsp_if.sv]
// ----------------------------------------------------------------------------
// ghe_rsp_if
// Result channel of the histogram engine: valid/ready plus one read-back word.
// ----------------------------------------------------------------------------
interface ghe_rsp_if;
   import ghe_pkg::*;

   logic                      valid;
   logic                      ready;
   logic [OUT_COUNT_BITS-1:0] bin_count;
   logic [BAR_BITS-1:0]       bar_height;

   modport source (output valid, output bin_count, output bar_height, input ready);
   modport sink   (input valid, input bin_count, input bar_height, output ready);
endinterface

[design/gray_histogram_engine_core.sv]
// ----------------------------------------------------------------------------
// gray_histogram_engine_core
// 256-bin saturating gray-level histogram with count, read and clear words.
// ----------------------------------------------------------------------------
// usage:
//   req_if carries one operation word: count (adds one to the bin of
//   pixel_value), read (returns bin_index's count) or clear (zeroes all bins).
//   the unused operation code is dropped. only a read produces a word on
//   rsp_if: bin_count (clamped to 24 bits) and bar_height (clamped to 255).
//   a read moves through the update stage and then the result register.
//   throughput: one word per cycle for any mix of operations, unless a
//   stalled read backs up the input (see below); bins live in a 256-entry
//   memory with one read and one write port, and the read-modify-write of
//   a count spans the memory read and the update stage, with forwarding
//   between back-to-back updates of the same bin. reset clears every bin
//   at once through per-bin valid flags, with no sweep; a clear word does the same.
//   if the receiver stalls, one read waits in the result register and a
//   second one waits in the update stage; counts and clears keep flowing
//   until a read meets that full stage, then req_if.ready drops.
// ----------------------------------------------------------------------------
module gray_histogram_engine_core #(
   parameter int COUNT_BITS = ghe_pkg::COUNT_BITS_DEF
) (
   input  logic   clock,
   input  logic   reset,
   ghe_req_if.sink   req_if,
   ghe_rsp_if.source rsp_if
);
   import ghe_pkg::*;

   localparam int WIDE_BITS = (COUNT_BITS > OUT_COUNT_BITS) ? COUNT_BITS : OUT_COUNT_BITS;
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

   // bin storage
   logic [COUNT_BITS-1:0]   bin_mem [NUM_BINS];
   logic [NUM_BINS-1:0]     bin_valid_ff;

   // update stage
   logic                    s1_valid_ff;
   op_type                  s1_op_ff;
   logic [BIN_IDX_BITS-1:0] s1_addr_ff;
   logic [COUNT_BITS-1:0]   s1_mem_ff;
   logic                    s1_zero_ff;
   logic                    s1_fwd_ff;
   logic [COUNT_BITS-1:0]   s1_fwd_data_ff;

   // result register
   logic                      rsp_valid_ff;
   logic [OUT_COUNT_BITS-1:0] rsp_count_ff;
   logic [BAR_BITS-1:0]       rsp_bar_ff;

   logic                      req_fire;
   op_type                    req_op;
   logic                      req_known;
   logic [BIN_IDX_BITS-1:0]   req_addr;
   logic                      s1_go;
   logic                      wr_en;
   logic                      clr_en;
   logic [COUNT_BITS-1:0]     cur_count;
   logic [COUNT_BITS-1:0]     wr_data;
   logic [WIDE_BITS-1:0]      cur_wide;
   logic [OUT_COUNT_BITS-1:0] shown_count;
   logic [BAR_BITS-1:0]       shown_bar;

   always_comb begin
      req_op    = op_type'(req_if.operation);
      req_known = 1'b1;
      req_addr  = req_if.bin_index;
      unique case (req_if.operation)
         OP_COUNT: req_addr = req_if.pixel_value;
         OP_READ:  req_addr = req_if.bin_index;
         OP_CLEAR: req_addr = req_if.bin_index;
         default:  req_known = 1'b0;
      endcase
   end

   assign s1_go         = s1_valid_ff && ((s1_op_ff != OP_READ) || !rsp_valid_ff || rsp_if.ready);
   assign req_if.ready  = !s1_valid_ff || s1_go;
   assign req_fire      = req_if.valid && req_if.ready;

   // current bin value, newest write first
   always_comb begin
      if (s1_fwd_ff) begin
         cur_count = s1_fwd_data_ff;
      end else if (s1_zero_ff) begin
         cur_count = '0;
      end else begin
         cur_count = s1_mem_ff;
      end
   end

   assign wr_en   = s1_go && (s1_op_ff == OP_COUNT);
   assign clr_en  = s1_go && (s1_op_ff == OP_CLEAR);
   assign wr_data = (cur_count == COUNT_MAX) ? cur_count : cur_count + COUNT_BITS'(1);

   assign cur_wide    = WIDE_BITS'(cur_count);
   assign shown_count = (cur_wide > WIDE_BITS'(OUT_COUNT_MAX)) ? OUT_COUNT_MAX
                                                               : cur_wide[OUT_COUNT_BITS-1:0];
   assign shown_bar   = (cur_count > COUNT_BITS'(BAR_MAX)) ? BAR_MAX
                                                           : cur_count[BAR_BITS-1:0];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         bin_mem[s1_addr_ff] <= wr_data;
      end
      if (req_fire) begin
         s1_mem_ff <= bin_mem[req_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset || clr_en) begin
         bin_valid_ff <= '0;
      end else if (wr_en) begin
         bin_valid_ff[s1_addr_ff] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_fire) begin
         s1_valid_ff <= req_known;
      end else if (s1_go) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_op_ff       <= req_op;
         s1_addr_ff     <= req_addr;
         s1_fwd_ff      <= wr_en && (s1_addr_ff == req_addr);
         s1_fwd_data_ff <= wr_data;
         s1_zero_ff     <= clr_en || !bin_valid_ff[req_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_go && (s1_op_ff == OP_READ)) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_go && (s1_op_ff == OP_READ)) begin
         rsp_count_ff <= shown_count;
         rsp_bar_ff   <= shown_bar;
      end
   end

   assign rsp_if.valid      = rsp_valid_ff;
   assign rsp_if.bin_count  = rsp_count_ff;
   assign rsp_if.bar_height = rsp_bar_ff;

   // a count never lowers a bin
   a_count_monotonic: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (wr_data >= cur_count))
      else $error("bin update lowered the count");

   // a clear leaves every bin empty
   a_clear_empties: assert property (@(posedge clock) disable iff (reset)
      clr_en |=> (bin_valid_ff == '0))
      else $error("bins not empty after clear");

   // a new result only comes from a read leaving the update stage
   a_rsp_from_read: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !$past(rsp_valid_ff)) |-> $past(s1_go && (s1_op_ff == OP_READ)))
      else $error("result without a read");

endmodule

[tb/ghe_histogram_checker.sv]
// ----------------------------------------------------------------------------
// ghe_histogram_checker
// Watches both channels of the histogram engine. It keeps its own copy of
// the 256 bins, updates them on every accepted count and clear word, and
// queues the bin count and bar height due for every accepted read word. It
// compares each accepted result word with the oldest queued readback.
// ----------------------------------------------------------------------------
module ghe_histogram_checker #(
   parameter int COUNT_BITS = ghe_pkg::COUNT_BITS_DEF
) (
   input  logic clock,
   input  logic reset,
   ghe_req_if   req_mon,
   ghe_rsp_if   rsp_mon,
   output int   mismatch_count,
   output int   reads_pending
);
   timeunit 1ns;
   timeprecision 1ps;

   import ghe_pkg::*;

   localparam logic [31:0] BIN_LIMIT = 32'((64'd1 << COUNT_BITS) - 64'd1);

   typedef struct packed {
      logic [OUT_COUNT_BITS-1:0] bin_count;
      logic [BAR_BITS-1:0]       bar_height;
   } readback_type;

   logic [31:0]  bin_model [NUM_BINS];
   readback_type readbacks_due [$];
   int           fail_total = 0;

   assign mismatch_count = fail_total;

   function automatic readback_type bin_readback(input logic [31:0] level_count);
      readback_type shown;
      shown.bin_count  = (level_count > 32'(OUT_COUNT_MAX)) ? OUT_COUNT_MAX
                                                           : level_count[OUT_COUNT_BITS-1:0];
      shown.bar_height = (level_count > 32'(BAR_MAX)) ? BAR_MAX
                                                     : level_count[BAR_BITS-1:0];
      return shown;
   endfunction

   task automatic report_mismatch(input string what, input int want, input int got);
      $display("%0t: %s expected %0d got %0d", $time, what, want, got);
      fail_total++;
   endtask

   always @(posedge clock) begin : track
      readback_type want;
      if (reset) begin
         for (int b = 0; b < NUM_BINS; b++) begin
            bin_model[b] = '0;
         end
         readbacks_due.delete();
      end else begin
         if (rsp_mon.valid === 1'b1 && rsp_mon.ready === 1'b1) begin
            if (readbacks_due.size() == 0) begin
               report_mismatch("unexpected word, bin_count", -1, int'(rsp_mon.bin_count));
            end else begin
               want = readbacks_due.pop_front();
               if (rsp_mon.bin_count !== want.bin_count) begin
                  report_mismatch("bin_count", int'(want.bin_count), int'(rsp_mon.bin_count));
               end
               if (rsp_mon.bar_height !== want.bar_height) begin
                  report_mismatch("bar_height", int'(want.bar_height),
                                  int'(rsp_mon.bar_height));
               end
            end
         end
         if (req_mon.valid === 1'b1 && req_mon.ready === 1'b1) begin
            case (req_mon.operation)
               OP_COUNT: begin
                  if (bin_model[req_mon.pixel_value] < BIN_LIMIT) begin
                     bin_model[req_mon.pixel_value] += 32'd1;
                  end
               end
               OP_READ: begin
                  readbacks_due.push_back(bin_readback(bin_model[req_mon.bin_index]));
               end
               OP_CLEAR: begin
                  for (int b = 0; b < NUM_BINS; b++) begin
                     bin_model[b] = '0;
                  end
               end
               default: ;
            endcase
         end
      end
      reads_pending <= readbacks_due.size();
   end

endmodule

[tb/tb_gray_histogram_engine_core.sv]
// ----------------------------------------------------------------------------
// tb_gray_histogram_engine_core
// Stimulus and verdict for the histogram engine. Runs directed words at the
// bin and level extremes, a bar clamp burst on one bin, then random mixes
// of count, read, clear and unused words under changing idle patterns on
// both sides, plus one long result hold-off that backs up the input.
// ----------------------------------------------------------------------------
module tb_gray_histogram_engine_core;
   timeunit 1ns;
   timeprecision 1ps;

   import ghe_pkg::*;

   localparam int HIST_COUNT_BITS = 17;
   localparam int CYCLE_LIMIT     = 1_000_000;
   localparam int DRAIN_CYCLES    = 16;
   localparam int HOLD_OFF_CYCLES = 400;
   localparam int PHASE_WORDS     = 300;
   localparam int SAT_BIN         = 128;
   localparam int BURST_COUNTS    = 260;

   localparam logic [OP_BITS-1:0] OP_UNUSED = 2'd3;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   send_idle_pct = 0;
   int   recv_stall_pct = 0;
   bit   hold_off_request = 1'b0;
   int   cycle_count = 0;
   int   mismatch_count;
   int   reads_pending;

   ghe_req_if req_if ();
   ghe_rsp_if rsp_if ();

   gray_histogram_engine_core #(
      .COUNT_BITS (HIST_COUNT_BITS)
   ) dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

   ghe_histogram_checker #(
      .COUNT_BITS (HIST_COUNT_BITS)
   ) u_hist_check (
      .clock          (clock),
      .reset          (reset),
      .req_mon        (req_if),
      .rsp_mon        (rsp_if),
      .mismatch_count (mismatch_count),
      .reads_pending  (reads_pending)
   );

   always #10 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("** gray_histogram_engine_core: FAILED **");
         $finish;
      end
   end

   initial begin : receiver
      int  hold_left;
      bit  hold_served;
      hold_left   = 0;
      hold_served = 1'b0;
      rsp_if.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off_request && !hold_served) begin
            hold_left   = HOLD_OFF_CYCLES;
            hold_served = 1'b1;
         end
         if (hold_left > 0) begin
            rsp_if.ready <= 1'b0;
            hold_left--;
         end else begin
            rsp_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
         end
      end
   end

   function automatic logic [7:0] pick_level();
      if ($urandom_range(0, 1) == 0) begin
         return 8'($urandom_range(0, 3));
      end
      return 8'($urandom_range(0, 255));
   endfunction

   task automatic send_word(input logic [OP_BITS-1:0]      op,
                            input logic [PIX_BITS-1:0]     pix,
                            input logic [BIN_IDX_BITS-1:0] idx);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid       <= 1'b1;
      req_if.operation   <= op;
      req_if.pixel_value <= pix;
      req_if.bin_index   <= idx;
      @(posedge clock);
      while (req_if.ready !== 1'b1) begin
         @(posedge clock);
      end
   endtask

   task automatic send_random_word();
      int                 pick;
      logic [OP_BITS-1:0] op;
      pick = $urandom_range(0, 99);
      if (pick < 56) begin
         op = OP_COUNT;
      end else if (pick < 92) begin
         op = OP_READ;
      end else if (pick < 94) begin
         op = OP_CLEAR;
      end else begin
         op = OP_UNUSED;
      end
      send_word(op, pick_level(), pick_level());
   endtask

   task automatic run_phase(input int send_pct, input int recv_pct);
      send_idle_pct  <= send_pct;
      recv_stall_pct <= recv_pct;
      for (int n = 0; n < PHASE_WORDS; n++) begin
         send_random_word();
      end
   endtask

   initial begin : stimulus
      req_if.valid       = 1'b0;
      req_if.operation   = OP_COUNT;
      req_if.pixel_value = '0;
      req_if.bin_index   = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // empty bins after reset, extremes, same-bin updates back to back
      send_word(OP_READ,   8'hA5, 8'd0);
      send_word(OP_READ,   8'h5A, 8'd255);
      send_word(OP_COUNT,  8'd0,   8'hFF);
      send_word(OP_COUNT,  8'd255, 8'h00);
      send_word(OP_COUNT,  8'd255, 8'h3C);
      send_word(OP_COUNT,  8'd255, 8'hC3);
      send_word(OP_READ,   8'hFF, 8'd255);
      send_word(OP_READ,   8'h00, 8'd0);
      send_word(OP_COUNT,  8'd7,   8'd7);
      send_word(OP_READ,   8'd7,   8'd7);
      send_word(OP_UNUSED, 8'd7,   8'd7);
      send_word(OP_UNUSED, 8'hFF, 8'hFF);
      send_word(OP_READ,   8'd0,   8'd7);
      send_word(OP_CLEAR,  8'hFF, 8'hFF);
      send_word(OP_READ,   8'd0,   8'd255);
      send_word(OP_READ,   8'd255, 8'd0);
      send_word(OP_COUNT,  8'd0,   8'd0);
      send_word(OP_READ,   8'd0,   8'd0);
      send_word(OP_COUNT,  8'd128, 8'd127);
      send_word(OP_CLEAR,  8'd0,   8'd0);
      send_word(OP_READ,   8'd127, 8'd128);

      // one bin through the bar clamp
      for (int n = 0; n < BURST_COUNTS; n++) begin
         send_word(OP_COUNT, 8'(SAT_BIN), 8'($urandom_range(0, 255)));
         if (n >= 253 && n <= 256) begin
            send_word(OP_READ, 8'($urandom_range(0, 255)), 8'(SAT_BIN));
         end
      end
      send_word(OP_READ,  8'd0, 8'(SAT_BIN));
      send_word(OP_COUNT, 8'(SAT_BIN), 8'd0);
      send_word(OP_READ,  8'd0, 8'(SAT_BIN));
      send_word(OP_CLEAR, 8'd0, 8'd0);
      send_word(OP_READ,  8'd0, 8'(SAT_BIN));

      run_phase(35, 54);

      // long result hold-off while reads keep coming
      send_idle_pct  <= 0;
      recv_stall_pct <= 0;
      hold_off_request <= 1'b1;
      for (int n = 0; n < 40; n++) begin
         send_word((n % 2 == 0) ? OP_READ : OP_COUNT, pick_level(), pick_level());
      end

      run_phase(54, 35);
      run_phase(0, 0);

      req_if.valid   <= 1'b0;
      recv_stall_pct <= 0;
      @(posedge clock);
      while (reads_pending != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("** gray_histogram_engine_core: PASSED **");
      end else begin
         $display("** gray_histogram_engine_core: FAILED **");
      end
      $finish;
   end

endmodule
